// File: design/assert_macros.svh
// assertion macros for the design files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// condition holds at every clock edge out of reset
`define DQE_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// consequent holds in the same cycle as the antecedent
`define DQE_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// consequent holds in the cycle after the antecedent
`define DQE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`else

`define DQE_ASSERT_ALWAYS(lbl, cond, msg)
`define DQE_ASSERT_IMPL(lbl, ante, cons, msg)
`define DQE_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

// File: design/dqe_pkg.sv
// shared constants, types and helpers of the dns question encoder
`timescale 1ns / 1ps

package dqe_pkg;

  // default limits
  localparam int NAME_MAX_DFLT   = 256;
  localparam int STRING_MAX_DFLT = 1024;
  localparam int LABEL_MAX_DFLT  = 63;

  // field widths
  localparam int BYTE_W    = 8;
  localparam int QTOT_W    = 10;
  localparam int CFG_IDX_W = 2;

  localparam logic [QTOT_W-1:0] QTOT_MAX = '1;

  // question trailer values
  localparam logic [BYTE_W-1:0] TYPE_A    = 8'd1;
  localparam logic [BYTE_W-1:0] TYPE_AAAA = 8'd28;
  localparam logic [BYTE_W-1:0] CLASS_IN  = 8'd1;

  // trailer slots: empty label, terminator, type hi, type lo, class hi, class lo
  localparam logic [2:0] TAIL_TYPE_LO  = 3'd3;
  localparam logic [2:0] TAIL_CLASS_LO = 3'd5;

  typedef enum logic [1:0] {
    ERR_NONE   = 2'd0,
    ERR_NAME   = 2'd1,
    ERR_STRING = 2'd2,
    ERR_LABEL  = 2'd3
  } err_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_USE_AAAA  = 2'd0,
    CFG_LABEL_SEP = 2'd1,
    CFG_QUERY_SEP = 2'd2
  } cfg_idx_t;

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } seq_state_t;

  // one result pair between the read stage and the output register
  typedef struct packed {
    logic              mem0;
    logic              mem1;
    logic [BYTE_W-1:0] k0;
    logic [BYTE_W-1:0] k1;
    logic [1:0]        cnt;
    logic              last;
    logic [QTOT_W-1:0] qtot;
    err_t              code;
  } pair_t;

  // byte of the question trailer at a given slot
  function automatic logic [BYTE_W-1:0] tail_byte(logic [2:0] idx, logic aaaa);
    logic [BYTE_W-1:0] b;
    b = '0;
    if (idx == TAIL_TYPE_LO) begin
      b = aaaa ? TYPE_AAAA : TYPE_A;
    end else if (idx == TAIL_CLASS_LO) begin
      b = CLASS_IN;
    end
    return b;
  endfunction

endpackage

// File: design/dqe_if.sv
// handshake channels of the dns question encoder
`timescale 1ns / 1ps

// character input channel
interface dqe_in_if;
  logic                       valid;
  logic                       ready;
  logic [dqe_pkg::BYTE_W-1:0] char_in;
  logic                       end_of_string;

  modport source (output valid, output char_in, output end_of_string, input ready);
  modport sink (input valid, input char_in, input end_of_string, output ready);
endinterface

// question byte output channel
interface dqe_out_if;
  logic                       valid;
  logic                       ready;
  logic [dqe_pkg::BYTE_W-1:0] byte_first;
  logic [dqe_pkg::BYTE_W-1:0] byte_second;
  logic [1:0]                 byte_count;
  logic                       run_last;
  logic [dqe_pkg::QTOT_W-1:0] query_total;
  logic [1:0]                 error_code;

  modport source (output valid, output byte_first, output byte_second, output byte_count,
                  output run_last, output query_total, output error_code, input ready);
  modport sink (input valid, input byte_first, input byte_second, input byte_count,
                input run_last, input query_total, input error_code, output ready);
endinterface

// configuration write channel
interface dqe_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [dqe_pkg::CFG_IDX_W-1:0] index;
  logic [dqe_pkg::BYTE_W-1:0]    data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// File: design/dqe_label_ram.sv
// label buffer ram: one write port, two registered read ports
`timescale 1ns / 1ps

module dqe_label_ram #(
  parameter int DEPTH = dqe_pkg::LABEL_MAX_DFLT,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                       clk,
  input  logic                       we,
  input  logic [AW-1:0]              waddr,
  input  logic [dqe_pkg::BYTE_W-1:0] wdata,
  input  logic                       re,
  input  logic [AW-1:0]              raddr0,
  input  logic [AW-1:0]              raddr1,
  output logic [dqe_pkg::BYTE_W-1:0] rdata0,
  output logic [dqe_pkg::BYTE_W-1:0] rdata1
);

  logic [dqe_pkg::BYTE_W-1:0] mem [DEPTH];
  logic [dqe_pkg::BYTE_W-1:0] rd0_r;
  logic [dqe_pkg::BYTE_W-1:0] rd1_r;

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read ports, data held until the next read
  always_ff @(posedge clk) begin
    if (re) begin
      rd0_r <= mem[raddr0];
      rd1_r <= mem[raddr1];
    end
  end

  assign rdata0 = rd0_r;
  assign rdata1 = rd1_r;

endmodule

// File: design/dns_question_encoder_unit.sv
// Top level of the dns question encoder: character intake, byte sequencer, output register.
// An ordinary character within the limits goes into the label buffer; no result unless it ends the string.
// A separator or final character runs the sequencer: ceil(n/2) results, n = label
//   length plus up to 7 more bytes, one result per cycle from the two read ports unless stalled.
// Results pass the read stage and output register; input is ready the cycle after the last read.
// Reset (synchronous, rst_n low) clears lengths, counter and error, restores config defaults.
`timescale 1ns / 1ps

`include "assert_macros.svh"

module dns_question_encoder_unit #(
  parameter int NAME_MAX   = dqe_pkg::NAME_MAX_DFLT,
  parameter int STRING_MAX = dqe_pkg::STRING_MAX_DFLT,
  parameter int LABEL_MAX  = dqe_pkg::LABEL_MAX_DFLT
) (
  input logic          clk,
  input logic          rst_n,
  dqe_in_if.sink       in_chan,
  dqe_out_if.source    out_chan,
  dqe_cfg_if.sink      cfg_chan
);

  localparam int LW = $clog2(LABEL_MAX + 1);
  localparam int NW = $clog2(NAME_MAX + 1);
  localparam int SW = $clog2(STRING_MAX + 1);
  localparam int TW = $clog2(LABEL_MAX + 9);
  localparam int AW = (LABEL_MAX > 1) ? $clog2(LABEL_MAX) : 1;
  localparam int BW = dqe_pkg::BYTE_W;
  localparam int QW = dqe_pkg::QTOT_W;

  // string state
  logic [LW-1:0]      lbl_len_r, lbl_len_nxt;
  logic [NW-1:0]      name_len_r, name_len_nxt;
  logic [SW-1:0]      str_len_r, str_len_nxt;
  logic [QW-1:0]      qcnt_r, qcnt_nxt, qcnt_step;
  dqe_pkg::err_t      err_r, err_nxt, err_step;

  // configuration
  logic               aaaa_r;
  logic [BW-1:0]      lsep_r;
  logic [BW-1:0]      qsep_r;

  // sequencer
  dqe_pkg::seq_state_t state_r, state_nxt;
  logic [TW-1:0]      pos_r;
  logic [TW-1:0]      total_r;
  logic [LW-1:0]      flen_r;
  logic               ts_r;
  logic               report_r;
  dqe_pkg::err_t      rcode_r;
  logic [QW-1:0]      rqtot_r;

  // intake decisions
  logic               in_fire;
  logic               is_q, is_l;
  logic               wr_en;
  logic               go_run, go_report, go_ts;
  logic [LW-1:0]      go_len;
  logic [TW-1:0]      go_total;

  // issue stage
  logic               issue;
  logic               out_free;
  logic               s1_move;
  logic [TW-1:0]      q_pos [2];
  logic [TW-1:0]      tfull [2];
  logic               src_mem [2];
  logic [AW-1:0]      src_addr [2];
  logic [BW-1:0]      src_k [2];
  logic [1:0]         iss_cnt;
  logic               iss_last;
  logic [TW:0]        pos_ahead;
  dqe_pkg::pair_t     s1_r, s1_nxt;
  logic               s1_valid_r;
  logic [BW-1:0]      rd0, rd1;

  // output register
  logic               out_valid_r;
  logic [BW-1:0]      out_b0_r, out_b1_r;
  logic [1:0]         out_cnt_r;
  logic               out_last_r;
  logic [QW-1:0]      out_qtot_r;
  dqe_pkg::err_t      out_code_r;

  assign in_fire        = in_chan.valid && in_chan.ready;
  assign in_chan.ready  = (state_r == dqe_pkg::ST_IDLE);
  assign cfg_chan.ready = 1'b1;

  assign is_q = (in_chan.char_in == qsep_r);
  assign is_l = (in_chan.char_in == lsep_r);

  // intake: update string state and set up the byte run
  always_comb begin
    lbl_len_nxt  = lbl_len_r;
    name_len_nxt = name_len_r;
    str_len_nxt  = str_len_r;
    qcnt_step    = qcnt_r;
    err_step     = err_r;
    wr_en        = 1'b0;
    go_report    = 1'b0;
    go_ts        = 1'b0;
    go_len       = lbl_len_r;
    go_total     = '0;
    if (in_fire) begin
      if (err_r != dqe_pkg::ERR_NONE) begin
        go_report = in_chan.end_of_string;
      end else if (str_len_r == SW'(STRING_MAX)) begin
        err_step  = dqe_pkg::ERR_STRING;
        go_report = 1'b1;
      end else begin
        str_len_nxt = str_len_r + 1'b1;
        if (is_q) begin
          // close the query: label, terminator, type, class
          go_total     = TW'(lbl_len_r) + TW'(6);
          go_ts        = 1'b1;
          lbl_len_nxt  = '0;
          name_len_nxt = '0;
          qcnt_step    = (qcnt_r != dqe_pkg::QTOT_MAX) ? qcnt_r + 1'b1 : qcnt_r;
        end else if (name_len_r == NW'(NAME_MAX)) begin
          err_step  = dqe_pkg::ERR_NAME;
          go_report = 1'b1;
        end else if (is_l) begin
          name_len_nxt = name_len_r + 1'b1;
          lbl_len_nxt  = '0;
          if (in_chan.end_of_string) begin
            // label, then an empty label and the trailer
            go_total  = TW'(lbl_len_r) + TW'(7);
            qcnt_step = (qcnt_r != dqe_pkg::QTOT_MAX) ? qcnt_r + 1'b1 : qcnt_r;
          end else begin
            go_total = TW'(lbl_len_r) + TW'(1);
          end
        end else if (lbl_len_r == LW'(LABEL_MAX)) begin
          err_step  = dqe_pkg::ERR_LABEL;
          go_report = 1'b1;
        end else begin
          // ordinary character goes into the label buffer
          name_len_nxt = name_len_r + 1'b1;
          wr_en        = 1'b1;
          lbl_len_nxt  = lbl_len_r + 1'b1;
          if (in_chan.end_of_string) begin
            go_len    = lbl_len_r + 1'b1;
            go_total  = TW'(lbl_len_r) + TW'(7);
            go_ts     = 1'b1;
            qcnt_step = (qcnt_r != dqe_pkg::QTOT_MAX) ? qcnt_r + 1'b1 : qcnt_r;
          end
        end
      end
    end
    go_run  = in_fire && (go_report || (go_total != '0));
    qcnt_nxt = qcnt_step;
    err_nxt  = err_step;
    // end of string clears the string state
    if (in_fire && in_chan.end_of_string) begin
      lbl_len_nxt  = '0;
      name_len_nxt = '0;
      str_len_nxt  = '0;
      qcnt_nxt     = '0;
      err_nxt      = dqe_pkg::ERR_NONE;
    end
  end

  // string state and configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lbl_len_r  <= '0;
      name_len_r <= '0;
      str_len_r  <= '0;
      qcnt_r     <= '0;
      err_r      <= dqe_pkg::ERR_NONE;
      aaaa_r     <= 1'b0;
      lsep_r     <= 8'd46;
      qsep_r     <= 8'd44;
    end else begin
      lbl_len_r  <= lbl_len_nxt;
      name_len_r <= name_len_nxt;
      str_len_r  <= str_len_nxt;
      qcnt_r     <= qcnt_nxt;
      err_r      <= err_nxt;
      if (cfg_chan.valid && cfg_chan.ready) begin
        unique case (cfg_chan.index)
          dqe_pkg::CFG_USE_AAAA:  aaaa_r <= cfg_chan.data[0];
          dqe_pkg::CFG_LABEL_SEP: lsep_r <= cfg_chan.data;
          dqe_pkg::CFG_QUERY_SEP: qsep_r <= cfg_chan.data;
          default: ;
        endcase
      end
    end
  end

  // label buffer
  dqe_label_ram #(
    .DEPTH (LABEL_MAX),
    .AW    (AW)
  ) u_label_ram (
    .clk    (clk),
    .we     (wr_en),
    .waddr  (lbl_len_r[AW-1:0]),
    .wdata  (in_chan.char_in),
    .re     (issue),
    .raddr0 (src_addr[0]),
    .raddr1 (src_addr[1]),
    .rdata0 (rd0),
    .rdata1 (rd1)
  );

  assign out_free = !out_valid_r || out_chan.ready;
  assign s1_move  = s1_valid_r && out_free;
  assign issue    = (state_r == dqe_pkg::ST_RUN) && (!s1_valid_r || out_free);

  // byte source for the two positions of the current pair
  always_comb begin
    for (int i = 0; i < 2; i++) begin
      q_pos[i]    = pos_r + TW'(i);
      tfull[i]    = q_pos[i] - TW'(flen_r) - TW'(1) + TW'(ts_r);
      src_mem[i]  = (q_pos[i] != '0) && (q_pos[i] <= TW'(flen_r));
      src_addr[i] = src_mem[i] ? AW'(q_pos[i] - TW'(1)) : '0;
      src_k[i]    = (q_pos[i] == '0) ? BW'(flen_r) :
                    dqe_pkg::tail_byte(tfull[i][2:0], aaaa_r);
    end
  end

  // pair count and end of run
  always_comb begin
    pos_ahead = {1'b0, pos_r} + (TW+1)'(2);
    if (report_r) begin
      iss_cnt  = 2'd0;
      iss_last = 1'b1;
    end else begin
      iss_cnt  = (q_pos[1] < total_r) ? 2'd2 : 2'd1;
      iss_last = (pos_ahead >= {1'b0, total_r});
    end
    s1_nxt.mem0 = !report_r && src_mem[0];
    s1_nxt.k0   = report_r ? '0 : src_k[0];
    s1_nxt.mem1 = (iss_cnt == 2'd2) && src_mem[1];
    s1_nxt.k1   = (iss_cnt == 2'd2) ? src_k[1] : '0;
    s1_nxt.cnt  = iss_cnt;
    s1_nxt.last = iss_last;
    s1_nxt.qtot = rqtot_r;
    s1_nxt.code = report_r ? rcode_r : dqe_pkg::ERR_NONE;
  end

  // sequencer next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      dqe_pkg::ST_IDLE: begin
        if (go_run) begin
          state_nxt = dqe_pkg::ST_RUN;
        end
      end
      dqe_pkg::ST_RUN: begin
        if (issue && iss_last) begin
          state_nxt = dqe_pkg::ST_IDLE;
        end
      end
      default: state_nxt = dqe_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= dqe_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // run parameters and position counter
  always_ff @(posedge clk) begin
    if (go_run) begin
      pos_r    <= '0;
      total_r  <= go_total;
      flen_r   <= go_len;
      ts_r     <= go_ts;
      report_r <= go_report;
      rcode_r  <= err_step;
      rqtot_r  <= qcnt_step;
    end else if (issue) begin
      pos_r <= pos_ahead[TW-1:0];
    end
  end

  // read stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (issue) begin
      s1_valid_r <= 1'b1;
    end else if (s1_move) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      s1_r <= s1_nxt;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_move) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      out_b0_r   <= s1_r.mem0 ? rd0 : s1_r.k0;
      out_b1_r   <= s1_r.mem1 ? rd1 : s1_r.k1;
      out_cnt_r  <= s1_r.cnt;
      out_last_r <= s1_r.last;
      out_qtot_r <= s1_r.qtot;
      out_code_r <= s1_r.code;
    end
  end

  assign out_chan.valid       = out_valid_r;
  assign out_chan.byte_first  = out_b0_r;
  assign out_chan.byte_second = out_b1_r;
  assign out_chan.byte_count  = out_cnt_r;
  assign out_chan.run_last    = out_last_r;
  assign out_chan.query_total = out_qtot_r;
  assign out_chan.error_code  = out_code_r;

  // checks
  `DQE_ASSERT_ALWAYS(a_label_len_bound, lbl_len_r <= LW'(LABEL_MAX), "label length past limit")
  `DQE_ASSERT_IMPL(a_pos_in_run,
    (state_r == dqe_pkg::ST_RUN) && !report_r,
    pos_r < total_r, "sequencer position past run length")
  `DQE_ASSERT_IMPL(a_empty_is_report,
    s1_valid_r && (s1_r.cnt == 2'd0),
    s1_r.last && (s1_r.code != dqe_pkg::ERR_NONE), "empty result without error")
  `DQE_ASSERT_NEXT(a_eos_clears,
    in_fire && in_chan.end_of_string,
    (err_r == dqe_pkg::ERR_NONE) && (str_len_r == '0) && (qcnt_r == '0),
    "string state not cleared")

endmodule
